### hw/rtl/lpg_pkg.sv
// Shared constants for the line pixel generator.
package lpg_pkg;

    localparam int COORD_BITS = 12;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

endpackage

### hw/rtl/lpg_in_stage.sv
// Input register stage: holds one accepted request word until the core takes it.
module lpg_in_stage #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  logic                  i_req_type,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic                  i_adv,
    output logic                  o_valid,
    output logic                  o_req_type,
    output logic [COORD_BITS-1:0] o_start_x,
    output logic [COORD_BITS-1:0] o_start_y,
    output logic [COORD_BITS-1:0] o_end_x,
    output logic [COORD_BITS-1:0] o_end_y
);

    logic                  r_valid;
    logic                  r_req_type;
    logic [COORD_BITS-1:0] r_start_x;
    logic [COORD_BITS-1:0] r_start_y;
    logic [COORD_BITS-1:0] r_end_x;
    logic [COORD_BITS-1:0] r_end_y;
    logic                  n_valid;
    logic                  w_take;

    assign o_req_ready = !r_valid || i_adv;
    assign w_take      = i_req_valid && o_req_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_adv) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req_type <= i_req_type;
            r_start_x  <= i_start_x;
            r_start_y  <= i_start_y;
            r_end_x    <= i_end_x;
            r_end_y    <= i_end_y;
        end
    end

    assign o_valid    = r_valid;
    assign o_req_type = r_req_type;
    assign o_start_x  = r_start_x;
    assign o_start_y  = r_start_y;
    assign o_end_x    = r_end_x;
    assign o_end_y    = r_end_y;

endmodule

### hw/rtl/lpg_core.sv
// Line state, per-word Bresenham step and the result register.
module lpg_core #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_adv,
    input  logic                  i_req_type,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic                  o_pix_valid,
    input  logic                  i_pix_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last_pixel
);

    localparam int EB = COORD_BITS + 3;   // error term and diagonal increment
    localparam int SB = COORD_BITS + 2;   // straight increment

    // line state
    logic                  r_busy;
    logic [COORD_BITS-1:0] r_cur_x;
    logic [COORD_BITS-1:0] r_cur_y;
    logic signed [EB-1:0]  r_err;
    logic signed [EB-1:0]  r_diag;
    logic [SB-1:0]         r_straight;
    logic [COORD_BITS-1:0] r_steps;
    logic                  r_x_major;
    logic                  r_x_down;
    logic                  r_y_down;

    logic                  n_busy;
    logic [COORD_BITS-1:0] n_cur_x;
    logic [COORD_BITS-1:0] n_cur_y;
    logic signed [EB-1:0]  n_err;
    logic signed [EB-1:0]  n_diag;
    logic [SB-1:0]         n_straight;
    logic [COORD_BITS-1:0] n_steps;
    logic                  n_x_major;
    logic                  n_x_down;
    logic                  n_y_down;

    // result register
    logic                  r_o_valid;
    logic [COORD_BITS-1:0] r_o_x;
    logic [COORD_BITS-1:0] r_o_y;
    logic                  r_o_last;
    logic                  n_o_valid;
    logic                  w_emit;
    logic                  w_fire;

    // start decode
    logic signed [COORD_BITS:0] w_dx;
    logic signed [COORD_BITS:0] w_dy;
    logic [COORD_BITS:0]        w_adx_full;
    logic [COORD_BITS:0]        w_ady_full;
    logic [COORD_BITS-1:0]      w_adx;
    logic [COORD_BITS-1:0]      w_ady;
    logic                       w_xm;
    logic [COORD_BITS-1:0]      w_major;
    logic [COORD_BITS-1:0]      w_minor;
    logic [COORD_BITS-1:0]      w_x_dir;
    logic [COORD_BITS-1:0]      w_y_dir;

    assign o_adv  = !r_o_valid || i_pix_ready;
    assign w_fire = i_valid && o_adv;

    assign w_dx = $signed({i_end_x[COORD_BITS-1], i_end_x})
                - $signed({i_start_x[COORD_BITS-1], i_start_x});
    assign w_dy = $signed({i_end_y[COORD_BITS-1], i_end_y})
                - $signed({i_start_y[COORD_BITS-1], i_start_y});
    assign w_adx_full = w_dx[COORD_BITS] ? (-w_dx) : w_dx;
    assign w_ady_full = w_dy[COORD_BITS] ? (-w_dy) : w_dy;
    assign w_adx      = w_adx_full[COORD_BITS-1:0];
    assign w_ady      = w_ady_full[COORD_BITS-1:0];
    assign w_xm       = w_adx > w_ady;
    assign w_major    = w_xm ? w_adx : w_ady;
    assign w_minor    = w_xm ? w_ady : w_adx;

    // +1 or -1 in two's complement
    assign w_x_dir = r_x_down ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
    assign w_y_dir = r_y_down ? {COORD_BITS{1'b1}} : COORD_BITS'(1);

    always_comb begin
        n_busy     = r_busy;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_err      = r_err;
        n_diag     = r_diag;
        n_straight = r_straight;
        n_steps    = r_steps;
        n_x_major  = r_x_major;
        n_x_down   = r_x_down;
        n_y_down   = r_y_down;
        w_emit     = 1'b0;
        if (w_fire) begin
            case (i_req_type)
                lpg_pkg::REQ_START: begin
                    w_emit     = 1'b1;
                    n_x_down   = w_dx[COORD_BITS];
                    n_y_down   = w_dy[COORD_BITS];
                    n_x_major  = w_xm;
                    n_err      = $signed({2'b00, w_minor, 1'b0})
                               - $signed({3'b000, w_major});
                    n_diag     = $signed({2'b00, w_minor, 1'b0})
                               - $signed({2'b00, w_major, 1'b0});
                    n_straight = {1'b0, w_minor, 1'b0};
                    n_steps    = w_major;
                    n_cur_x    = i_start_x;
                    n_cur_y    = i_start_y;
                    n_busy     = w_major != '0;
                end
                lpg_pkg::REQ_STEP: begin
                    if (r_busy) begin
                        w_emit = 1'b1;
                        if (!r_err[EB-1]) begin
                            // diagonal move: minor axis steps too
                            if (r_x_major) begin
                                n_cur_y = r_cur_y + w_y_dir;
                            end else begin
                                n_cur_x = r_cur_x + w_x_dir;
                            end
                            n_err = r_err + r_diag;
                        end else begin
                            n_err = r_err + $signed({1'b0, r_straight});
                        end
                        if (r_x_major) begin
                            n_cur_x = r_cur_x + w_x_dir;
                        end else begin
                            n_cur_y = r_cur_y + w_y_dir;
                        end
                        n_steps = r_steps - COORD_BITS'(1);
                        n_busy  = r_steps != COORD_BITS'(1);
                    end
                end
                default: begin
                    w_emit = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (w_emit) begin
            n_o_valid = 1'b1;
        end else if (i_pix_ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_err      <= '0;
            r_diag     <= '0;
            r_straight <= '0;
            r_steps    <= '0;
            r_x_major  <= 1'b0;
            r_x_down   <= 1'b0;
            r_y_down   <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_cur_x    <= n_cur_x;
            r_cur_y    <= n_cur_y;
            r_err      <= n_err;
            r_diag     <= n_diag;
            r_straight <= n_straight;
            r_steps    <= n_steps;
            r_x_major  <= n_x_major;
            r_x_down   <= n_x_down;
            r_y_down   <= n_y_down;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_x    <= n_cur_x;
            r_o_y    <= n_cur_y;
            r_o_last <= !n_busy;
        end
    end

    assign o_pix_valid  = r_o_valid;
    assign o_pixel_x    = r_o_x;
    assign o_pixel_y    = r_o_y;
    assign o_last_pixel = r_o_last;

    a_idle_step_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_req_type == lpg_pkg::REQ_STEP && !r_busy) |=> !r_o_valid)
        else $error("step while idle produced a word");

    a_start_first_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_req_type == lpg_pkg::REQ_START)
        |=> (r_o_valid && r_o_x == $past(i_start_x) && r_o_y == $past(i_start_y)))
        else $error("start did not emit its first endpoint");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_last) |-> !r_busy)
        else $error("last pixel emitted while line still busy");

    a_busy_has_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_steps != '0))
        else $error("busy with no steps left");

endmodule

### hw/rtl/line_pixel_generator.sv
// Bresenham line rasterizer (all octants): one request word per clock unless the pixel output
// stalls, one pixel per step; a word passes the input register, then the error add-and-compare
// feeding the result register; the error term and position update is the loop that sets the rate.
module line_pixel_generator #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  logic                  i_req_type,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic                  o_pix_valid,
    input  logic                  i_pix_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last_pixel
);

    logic                  w_valid;
    logic                  w_adv;
    logic                  w_req_type;
    logic [COORD_BITS-1:0] w_start_x;
    logic [COORD_BITS-1:0] w_start_y;
    logic [COORD_BITS-1:0] w_end_x;
    logic [COORD_BITS-1:0] w_end_y;

    lpg_in_stage #(
        .COORD_BITS(COORD_BITS)
    ) u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req_type  (i_req_type),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_adv       (w_adv),
        .o_valid     (w_valid),
        .o_req_type  (w_req_type),
        .o_start_x   (w_start_x),
        .o_start_y   (w_start_y),
        .o_end_x     (w_end_x),
        .o_end_y     (w_end_y)
    );

    lpg_core #(
        .COORD_BITS(COORD_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_valid),
        .o_adv        (w_adv),
        .i_req_type   (w_req_type),
        .i_start_x    (w_start_x),
        .i_start_y    (w_start_y),
        .i_end_x      (w_end_x),
        .i_end_y      (w_end_y),
        .o_pix_valid  (o_pix_valid),
        .i_pix_ready  (i_pix_ready),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_last_pixel (o_last_pixel)
    );

endmodule

### dv/lpg_checker.sv
`timescale 1ns / 1ps
// Pixel predictor and scoreboard for the line pixel generator.
module lpg_checker #(
    parameter int CB = lpg_pkg::COORD_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_ready,
    input  logic          i_req_type,
    input  logic [CB-1:0] i_start_x,
    input  logic [CB-1:0] i_start_y,
    input  logic [CB-1:0] i_end_x,
    input  logic [CB-1:0] i_end_y,
    input  logic          i_pix_valid,
    input  logic          i_pix_ready,
    input  logic [CB-1:0] i_pixel_x,
    input  logic [CB-1:0] i_pixel_y,
    input  logic          i_last_pixel,
    output int            o_mismatches,
    output int            o_pending
);

    typedef logic signed [CB-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_pixel;

    t_pixel pending_pixels[$];

    int mismatch_count = 0;
    int pending_count = 0;

    // line walker state
    t_coord               walk_x = '0;
    t_coord               walk_y = '0;
    logic signed [CB+2:0] err_term = '0;
    logic signed [CB+2:0] diag_inc = '0;
    logic signed [CB+1:0] straight_inc = '0;
    logic [CB-1:0]        steps_left = '0;
    logic                 x_major = 1'b0;
    logic                 x_down = 1'b0;
    logic                 y_down = 1'b0;
    logic                 line_busy = 1'b0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    task automatic walk_line(input logic kind, input t_coord sx, input t_coord sy,
                             input t_coord ex, input t_coord ey);
        int dx;
        int dy;
        int major;
        int minor;
        if (kind == lpg_pkg::REQ_START) begin
            dx = int'(ex) - int'(sx);
            dy = int'(ey) - int'(sy);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            x_down = ex < sx;
            y_down = ey < sy;
            // ties go to y
            x_major = dx > dy;
            major = x_major ? dx : dy;
            minor = x_major ? dy : dx;
            err_term = (CB+3)'(2 * minor - major);
            diag_inc = (CB+3)'(2 * (minor - major));
            straight_inc = (CB+2)'(2 * minor);
            steps_left = CB'(major);
            walk_x = sx;
            walk_y = sy;
            line_busy = major != 0;
            pending_pixels.push_back('{sx, sy, major == 0});
        end else if (line_busy) begin
            if (err_term >= 0) begin
                if (x_major) walk_y = t_coord'(walk_y + (y_down ? -1 : 1));
                else         walk_x = t_coord'(walk_x + (x_down ? -1 : 1));
                err_term = err_term + diag_inc;
            end else begin
                err_term = err_term + straight_inc;
            end
            if (x_major) walk_x = t_coord'(walk_x + (x_down ? -1 : 1));
            else         walk_y = t_coord'(walk_y + (y_down ? -1 : 1));
            steps_left = steps_left - 1'b1;
            line_busy = steps_left != 0;
            pending_pixels.push_back('{walk_x, walk_y, steps_left == 0});
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            walk_x = '0;
            walk_y = '0;
            err_term = '0;
            diag_inc = '0;
            straight_inc = '0;
            steps_left = '0;
            x_major = 1'b0;
            x_down = 1'b0;
            y_down = 1'b0;
            line_busy = 1'b0;
            pending_pixels.delete();
        end else begin
            if (i_pix_valid && i_pix_ready) begin
                if (pending_pixels.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $realtime,
                                 t_coord'(i_pixel_x), t_coord'(i_pixel_y), i_last_pixel);
                    mismatch_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (want.x !== i_pixel_x || want.y !== i_pixel_y
                            || want.last !== i_last_pixel) begin
                        if (mismatch_count < 10)
                            $display({"%0t: pixel mismatch exp x=%0d y=%0d last=%0b,",
                                      " got x=%0d y=%0d last=%0b"},
                                     $realtime, want.x, want.y, want.last,
                                     t_coord'(i_pixel_x), t_coord'(i_pixel_y),
                                     i_last_pixel);
                        mismatch_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                walk_line(i_req_type, i_start_x, i_start_y, i_end_x, i_end_y);
        end
        pending_count = pending_pixels.size();
    end

endmodule

### dv/tb_line_pixel_generator.sv
`timescale 1ns / 1ps
// Testbench top for the line pixel generator: request stimulus and final verdict.
module tb_line_pixel_generator;

    localparam int CB = lpg_pkg::COORD_BITS;

    typedef logic signed [CB-1:0] t_coord;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    logic          req_type = lpg_pkg::REQ_STEP;
    logic [CB-1:0] start_x = '0;
    logic [CB-1:0] start_y = '0;
    logic [CB-1:0] end_x = '0;
    logic [CB-1:0] end_y = '0;
    logic          pix_valid;
    logic          pix_ready = 1'b0;
    logic [CB-1:0] pixel_x;
    logic [CB-1:0] pixel_y;
    logic          last_pixel;

    int mismatches;
    int pending;
    int words_sent = 0;
    bit steady = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    line_pixel_generator #(.COORD_BITS(CB)) i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .o_req_ready  (req_ready),
        .i_req_type   (req_type),
        .i_start_x    (start_x),
        .i_start_y    (start_y),
        .i_end_x      (end_x),
        .i_end_y      (end_y),
        .o_pix_valid  (pix_valid),
        .i_pix_ready  (pix_ready),
        .o_pixel_x    (pixel_x),
        .o_pixel_y    (pixel_y),
        .o_last_pixel (last_pixel)
    );

    lpg_checker #(.CB(CB)) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req_type   (req_type),
        .i_start_x    (start_x),
        .i_start_y    (start_y),
        .i_end_x      (end_x),
        .i_end_y      (end_y),
        .i_pix_valid  (pix_valid),
        .i_pix_ready  (pix_ready),
        .i_pixel_x    (pixel_x),
        .i_pixel_y    (pixel_y),
        .i_last_pixel (last_pixel),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always @(posedge clk)
        pix_ready <= steady || ($urandom_range(99) >= 32);

    function automatic t_coord any_coord();
        return t_coord'($urandom);
    endfunction

    task automatic send_word(input logic kind, input t_coord sx, input t_coord sy,
                             input t_coord ex, input t_coord ey);
        while (!steady && $urandom_range(99) < 32) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        start_x   <= sx;
        start_y   <= sy;
        end_x     <= ex;
        end_y     <= ey;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic step_word();
        send_word(lpg_pkg::REQ_STEP, any_coord(), any_coord(), any_coord(), any_coord());
    endtask

    task automatic steps(input int n);
        repeat (n) step_word();
    endtask

    task automatic start_line(input int sx, input int sy, input int ex, input int ey);
        send_word(lpg_pkg::REQ_START, t_coord'(sx), t_coord'(sy), t_coord'(ex), t_coord'(ey));
    endtask

    initial begin
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
        int     dx;
        int     dy;
        int     len;
        int     n;
        int     pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: step with no line, single point, extremes, octants, abandon
        step_word();
        start_line(2047, -2048, 2047, -2048);
        step_word();
        start_line(-2048, 2047, 2047, -2048);
        steps(2);
        start_line(0, 0, 3, -1);
        steps(4);
        start_line(1, 1, -1, 4);
        steps(3);
        start_line(0, 0, -2, -2);
        steps(2);
        start_line(-2048, 0, 2047, 5);
        step_word();
        start_line(-5, 7, -5, 2);
        steps(5);

        // random lines: mostly walked to the end, some cut short, some noise
        while (words_sent < 1225) begin
            steady = words_sent >= 500 && words_sent < 700;
            pick = $urandom_range(99);
            if (pick < 8) begin
                step_word();
            end else begin
                sx = any_coord();
                sy = any_coord();
                if (pick < 18) begin
                    ex = any_coord();
                    ey = any_coord();
                end else begin
                    ex = sx + t_coord'($urandom_range(40) - 20);
                    ey = sy + t_coord'($urandom_range(40) - 20);
                end
                dx = int'(ex) - int'(sx);
                dy = int'(ey) - int'(sy);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                len = dx > dy ? dx : dy;
                if ($urandom_range(99) < 70) n = len + $urandom_range(2);
                else n = $urandom_range(len);
                if (n > 64) n = 64;
                send_word(lpg_pkg::REQ_START, sx, sy, ex, ey);
                steps(n);
            end
        end

        req_valid <= 1'b0;
        steady = 1'b1;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

### line_pixel_generator.f
hw/rtl/lpg_pkg.sv
hw/rtl/lpg_in_stage.sv
hw/rtl/lpg_core.sv
hw/rtl/line_pixel_generator.sv
dv/lpg_checker.sv
dv/tb_line_pixel_generator.sv
